[rtl/mpeg_audio_frame_header_decoder_macros.svh]
// assertion macros shared by the frame header decoder
`ifndef MPEG_AUDIO_FRAME_HEADER_DECODER_MACROS_SVH
`define MPEG_AUDIO_FRAME_HEADER_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define MAFHD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mafhd check failed");

// next-cycle implication, disabled while reset is high
`define MAFHD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mafhd check failed");

`endif

[rtl/mafhd_pkg.sv]
// types, constants and lookup tables of the frame header decoder
package mafhd_pkg;

   localparam logic [10:0] SYNC_PATTERN = 11'd2047;

   // version code in header bits 20:19
   localparam logic [1:0] VCODE_MPEG25    = 2'b00;
   localparam logic [1:0] VCODE_RESERVED  = 2'b01;
   localparam logic [1:0] VCODE_MPEG2     = 2'b10;
   localparam logic [1:0] VCODE_MPEG1     = 2'b11;

   // reported version
   localparam logic [1:0] VERSION_MPEG1    = 2'd0;
   localparam logic [1:0] VERSION_MPEG2    = 2'd1;
   localparam logic [1:0] VERSION_MPEG25   = 2'd2;
   localparam logic [1:0] VERSION_RESERVED = 2'd3;

   // layer code in header bits 18:17
   localparam logic [1:0] LCODE_RESERVED = 2'b00;
   localparam logic [1:0] LCODE_LAYER3   = 2'b01;
   localparam logic [1:0] LCODE_LAYER2   = 2'b10;
   localparam logic [1:0] LCODE_LAYER1   = 2'b11;

   localparam logic [1:0] LAYER_NONE = 2'd0;
   localparam logic [1:0] LAYER_1    = 2'd1;
   localparam logic [1:0] LAYER_2    = 2'd2;

   localparam int unsigned FACTOR_WIDTH  = 18;
   localparam int unsigned PRODUCT_WIDTH = 26;
   localparam int unsigned RECIP_WIDTH   = 30;
   localparam int unsigned RECIP_SHIFT   = 42;
   localparam int unsigned FRAME_WIDTH   = 12;
   localparam int unsigned MULT_WIDTH    = PRODUCT_WIDTH + RECIP_WIDTH;

   localparam logic [FACTOR_WIDTH-1:0] FACTOR_LAYER1 = 18'd48000;
   localparam logic [FACTOR_WIDTH-1:0] FACTOR_FULL   = 18'd144000;
   localparam logic [FACTOR_WIDTH-1:0] FACTOR_HALF   = 18'd72000;

   localparam logic [15:0] SR_44100 = 16'd44100;
   localparam logic [15:0] SR_48000 = 16'd48000;
   localparam logic [15:0] SR_32000 = 16'd32000;
   localparam logic [15:0] SR_22050 = 16'd22050;
   localparam logic [15:0] SR_24000 = 16'd24000;
   localparam logic [15:0] SR_16000 = 16'd16000;
   localparam logic [15:0] SR_11025 = 16'd11025;
   localparam logic [15:0] SR_12000 = 16'd12000;
   localparam logic [15:0] SR_8000  = 16'd8000;

   // rounded-up reciprocals, exact for every product below 2^26
   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
   localparam logic [RECIP_WIDTH-1:0] RECIP_44100 =
      RECIP_WIDTH'((RECIP_ONE + 64'(SR_44100) - 64'd1) / 64'(SR_44100));
   localparam logic [RECIP_WIDTH-1:0] RECIP_48000 =
      RECIP_WIDTH'((RECIP_ONE + 64'(SR_48000) - 64'd1) / 64'(SR_48000));
   localparam logic [RECIP_WIDTH-1:0] RECIP_32000 =
      RECIP_WIDTH'((RECIP_ONE + 64'(SR_32000) - 64'd1) / 64'(SR_32000));
   localparam logic [RECIP_WIDTH-1:0] RECIP_22050 =
      RECIP_WIDTH'((RECIP_ONE + 64'(SR_22050) - 64'd1) / 64'(SR_22050));
   localparam logic [RECIP_WIDTH-1:0] RECIP_24000 =
      RECIP_WIDTH'((RECIP_ONE + 64'(SR_24000) - 64'd1) / 64'(SR_24000));
   localparam logic [RECIP_WIDTH-1:0] RECIP_16000 =
      RECIP_WIDTH'((RECIP_ONE + 64'(SR_16000) - 64'd1) / 64'(SR_16000));
   localparam logic [RECIP_WIDTH-1:0] RECIP_11025 =
      RECIP_WIDTH'((RECIP_ONE + 64'(SR_11025) - 64'd1) / 64'(SR_11025));
   localparam logic [RECIP_WIDTH-1:0] RECIP_12000 =
      RECIP_WIDTH'((RECIP_ONE + 64'(SR_12000) - 64'd1) / 64'(SR_12000));
   localparam logic [RECIP_WIDTH-1:0] RECIP_8000 =
      RECIP_WIDTH'((RECIP_ONE + 64'(SR_8000) - 64'd1) / 64'(SR_8000));

   localparam logic [8:0] RATE_V1_L1 [16] = '{
      9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
   localparam logic [8:0] RATE_V1_L2 [16] = '{
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
   localparam logic [8:0] RATE_V1_L3 [16] = '{
      9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
   localparam logic [8:0] RATE_LOW_L1 [16] = '{
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
   localparam logic [8:0] RATE_LOW_L23 [16] = '{
      9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

   typedef struct packed {
      logic        header_ok;
      logic [1:0]  mpeg_version;
      logic [1:0]  layer;
      logic        has_crc;
      logic [8:0]  bitrate_kbps;
      logic [15:0] sample_rate_hz;
      logic [2:0]  padding_bytes;
      logic [1:0]  channel_mode;
      logic [1:0]  mode_extension;
      logic [2:0]  flag_bits;
      logic [1:0]  emphasis;
   } fields_type;

   typedef struct packed {
      fields_type                fields;
      logic [FACTOR_WIDTH-1:0]   factor;
      logic [RECIP_WIDTH-1:0]    recip;
   } dec_type;

   typedef struct packed {
      fields_type                fields;
      logic [PRODUCT_WIDTH-1:0]  product;
      logic [RECIP_WIDTH-1:0]    recip;
   } prod_type;

   typedef struct packed {
      fields_type                fields;
      logic [FRAME_WIDTH-1:0]    quotient;
   } quot_type;

   function automatic logic [8:0] bitrate_lookup(input logic [1:0] vcode,
                                                 input logic [1:0] lcode,
                                                 input logic [3:0] bidx);
      logic       mpeg1_tab;
      logic [8:0] rate;
      mpeg1_tab = (vcode == VCODE_MPEG1) || (vcode == VCODE_RESERVED);
      unique case (lcode)
         LCODE_LAYER1: rate = mpeg1_tab ? RATE_V1_L1[bidx] : RATE_LOW_L1[bidx];
         LCODE_LAYER2: rate = mpeg1_tab ? RATE_V1_L2[bidx] : RATE_LOW_L23[bidx];
         LCODE_LAYER3: rate = mpeg1_tab ? RATE_V1_L3[bidx] : RATE_LOW_L23[bidx];
         default:      rate = 9'd0;
      endcase
      return rate;
   endfunction

   function automatic logic [15:0] sample_rate_lookup(input logic [1:0] vcode,
                                                      input logic [1:0] fidx);
      logic [15:0] rate;
      rate = 16'd0;
      unique case (vcode)
         VCODE_MPEG1: begin
            unique case (fidx)
               2'd0:    rate = SR_44100;
               2'd1:    rate = SR_48000;
               2'd2:    rate = SR_32000;
               default: rate = 16'd0;
            endcase
         end
         VCODE_MPEG2: begin
            unique case (fidx)
               2'd0:    rate = SR_22050;
               2'd1:    rate = SR_24000;
               2'd2:    rate = SR_16000;
               default: rate = 16'd0;
            endcase
         end
         VCODE_MPEG25: begin
            unique case (fidx)
               2'd0:    rate = SR_11025;
               2'd1:    rate = SR_12000;
               2'd2:    rate = SR_8000;
               default: rate = 16'd0;
            endcase
         end
         default: rate = 16'd0;
      endcase
      return rate;
   endfunction

   function automatic logic [RECIP_WIDTH-1:0] recip_lookup(input logic [1:0] vcode,
                                                          input logic [1:0] fidx);
      logic [RECIP_WIDTH-1:0] recip;
      recip = '0;
      unique case (vcode)
         VCODE_MPEG1: begin
            unique case (fidx)
               2'd0:    recip = RECIP_44100;
               2'd1:    recip = RECIP_48000;
               2'd2:    recip = RECIP_32000;
               default: recip = '0;
            endcase
         end
         VCODE_MPEG2: begin
            unique case (fidx)
               2'd0:    recip = RECIP_22050;
               2'd1:    recip = RECIP_24000;
               2'd2:    recip = RECIP_16000;
               default: recip = '0;
            endcase
         end
         VCODE_MPEG25: begin
            unique case (fidx)
               2'd0:    recip = RECIP_11025;
               2'd1:    recip = RECIP_12000;
               2'd2:    recip = RECIP_8000;
               default: recip = '0;
            endcase
         end
         default: recip = '0;
      endcase
      return recip;
   endfunction

endpackage

[rtl/mpeg_audio_frame_header_decoder.sv]
// top level of the mpeg audio frame header decoder
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  req_tdata[31:0] header word
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata[55:0] decoded fields
//
// one request per cycle sustained while rsp_tready is not held low
// the four stages are decode, factor multiply, reciprocal multiply and output register
// the 26 x 30 reciprocal multiply sets the longest path
// reset clears all valid bits; payload registers are not reset
// a stall on rsp holds the output register and each full stage with no empty stage after it, empty stages still fill
`include "mpeg_audio_frame_header_decoder_macros.svh"

module mpeg_audio_frame_header_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // header_word[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // header_ok[0], mpeg_version[2:1], layer[4:3],
                                   // has_crc[5], bitrate_kbps[14:6],
                                   // sample_rate_hz[30:15], padding_bytes[33:31],
                                   // channel_mode[35:34], mode_extension[37:36],
                                   // flag_bits[40:38], emphasis[42:41],
                                   // frame_bytes[54:43], zero[55]
);

   logic                 dec_valid;
   logic                 dec_ready;
   mafhd_pkg::dec_type   dec_stage;
   logic                 quot_valid;
   logic                 quot_ready;
   mafhd_pkg::quot_type  quot_stage;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [55:0]          rsp_data_ff;
   logic [55:0]          rsp_data_in;
   logic [mafhd_pkg::FRAME_WIDTH-1:0] frame_bytes;

   mafhd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_word   (req_tdata),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_stage (dec_stage)
   );

   mafhd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_stage  (dec_stage),
      .out_valid (quot_valid),
      .out_ready (quot_ready),
      .out_stage (quot_stage)
   );

   // length only for a valid header
   assign frame_bytes = quot_stage.fields.header_ok ?
                        quot_stage.quotient +
                        mafhd_pkg::FRAME_WIDTH'(quot_stage.fields.padding_bytes) :
                        '0;

   assign rsp_data_in = {1'b0,
                         frame_bytes,
                         quot_stage.fields.emphasis,
                         quot_stage.fields.flag_bits,
                         quot_stage.fields.mode_extension,
                         quot_stage.fields.channel_mode,
                         quot_stage.fields.padding_bytes,
                         quot_stage.fields.sample_rate_hz,
                         quot_stage.fields.bitrate_kbps,
                         quot_stage.fields.has_crc,
                         quot_stage.fields.layer,
                         quot_stage.fields.mpeg_version,
                         quot_stage.fields.header_ok};

   assign quot_ready   = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = quot_ready ? quot_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (quot_ready && quot_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `MAFHD_ASSERT_NEXT(a_accept_fills_decode, clock, reset, req_tvalid && req_tready, dec_valid)
   `MAFHD_ASSERT_NOW(a_bad_header_no_length, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[54:43] == 12'd0)
   `MAFHD_ASSERT_NOW(a_good_header_has_length, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[54:43] != 12'd0)
   `MAFHD_ASSERT_NEXT(a_result_held_on_stall, clock, reset, quot_valid && !quot_ready, quot_valid)

endmodule

[rtl/mafhd_decode.sv]
// first stage: field extraction and table lookups
module mafhd_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [31:0]         in_word,
   output logic                out_valid,
   input  logic                out_ready,
   output mafhd_pkg::dec_type  out_stage
);

   logic               valid_ff;
   logic               valid_in;
   mafhd_pkg::dec_type stage_ff;
   mafhd_pkg::dec_type stage_in;

   logic [1:0] vcode;
   logic [1:0] lcode;
   logic [3:0] bidx;
   logic [1:0] fidx;
   logic       sync_ok;

   assign vcode   = in_word[20:19];
   assign lcode   = in_word[18:17];
   assign bidx    = in_word[15:12];
   assign fidx    = in_word[11:10];
   assign sync_ok = in_word[31:21] == mafhd_pkg::SYNC_PATTERN;

   always_comb begin
      stage_in = '0;
      unique case (vcode)
         mafhd_pkg::VCODE_MPEG25:   stage_in.fields.mpeg_version = mafhd_pkg::VERSION_MPEG25;
         mafhd_pkg::VCODE_RESERVED: stage_in.fields.mpeg_version = mafhd_pkg::VERSION_RESERVED;
         mafhd_pkg::VCODE_MPEG2:    stage_in.fields.mpeg_version = mafhd_pkg::VERSION_MPEG2;
         default:                   stage_in.fields.mpeg_version = mafhd_pkg::VERSION_MPEG1;
      endcase
      // layer code counts down from layer I
      stage_in.fields.layer = (lcode == mafhd_pkg::LCODE_RESERVED) ?
                              mafhd_pkg::LAYER_NONE : 2'(3'd4 - {1'b0, lcode});
      stage_in.fields.has_crc        = ~in_word[16];
      stage_in.fields.bitrate_kbps   = mafhd_pkg::bitrate_lookup(vcode, lcode, bidx);
      stage_in.fields.sample_rate_hz = mafhd_pkg::sample_rate_lookup(vcode, fidx);
      stage_in.fields.header_ok      = sync_ok &&
                                       (stage_in.fields.sample_rate_hz != 16'd0) &&
                                       (stage_in.fields.bitrate_kbps != 9'd0);
      if (in_word[9]) begin
         stage_in.fields.padding_bytes =
            (stage_in.fields.layer == mafhd_pkg::LAYER_1) ? 3'd4 : 3'd1;
      end else begin
         stage_in.fields.padding_bytes = 3'd0;
      end
      stage_in.fields.channel_mode   = in_word[7:6];
      stage_in.fields.mode_extension = in_word[5:4];
      stage_in.fields.flag_bits      = {in_word[8], in_word[3], in_word[2]};
      stage_in.fields.emphasis       = in_word[1:0];
      priority if (stage_in.fields.layer == mafhd_pkg::LAYER_1) begin
         stage_in.factor = mafhd_pkg::FACTOR_LAYER1;
      end else if ((stage_in.fields.layer == mafhd_pkg::LAYER_2) ||
                   (stage_in.fields.mpeg_version == mafhd_pkg::VERSION_MPEG1)) begin
         stage_in.factor = mafhd_pkg::FACTOR_FULL;
      end else begin
         stage_in.factor = mafhd_pkg::FACTOR_HALF;
      end
      stage_in.recip = mafhd_pkg::recip_lookup(vcode, fidx);
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

[rtl/mafhd_scale.sv]
// second and third stages: factor times bitrate, then reciprocal multiply
module mafhd_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  mafhd_pkg::dec_type  in_stage,
   output logic                out_valid,
   input  logic                out_ready,
   output mafhd_pkg::quot_type out_stage
);

   logic                 prod_valid_ff;
   logic                 prod_valid_in;
   logic                 prod_ready;
   mafhd_pkg::prod_type  prod_ff;
   mafhd_pkg::prod_type  prod_in;

   logic                 quot_valid_ff;
   logic                 quot_valid_in;
   logic                 quot_ready;
   mafhd_pkg::quot_type  quot_ff;
   mafhd_pkg::quot_type  quot_in;

   logic [mafhd_pkg::MULT_WIDTH-1:0] mult;

   always_comb begin
      prod_in.fields  = in_stage.fields;
      prod_in.recip   = in_stage.recip;
      prod_in.product = mafhd_pkg::PRODUCT_WIDTH'(in_stage.factor) *
                        mafhd_pkg::PRODUCT_WIDTH'(in_stage.fields.bitrate_kbps);
   end

   // quotient by multiply with the rounded-up reciprocal of the sample rate
   assign mult = mafhd_pkg::MULT_WIDTH'(prod_ff.product) *
                 mafhd_pkg::MULT_WIDTH'(prod_ff.recip);

   always_comb begin
      quot_in.fields   = prod_ff.fields;
      quot_in.quotient = mult[mafhd_pkg::RECIP_SHIFT +: mafhd_pkg::FRAME_WIDTH];
   end

   assign quot_ready    = !quot_valid_ff || out_ready;
   assign prod_ready    = !prod_valid_ff || quot_ready;
   assign in_ready      = prod_ready;
   assign prod_valid_in = prod_ready ? in_valid : prod_valid_ff;
   assign quot_valid_in = quot_ready ? prod_valid_ff : quot_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         quot_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         quot_valid_ff <= quot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && in_valid) begin
         prod_ff <= prod_in;
      end
      if (quot_ready && prod_valid_ff) begin
         quot_ff <= quot_in;
      end
   end

   assign out_valid = quot_valid_ff;
   assign out_stage = quot_ff;

endmodule
